[rtl/cholesky_factorizer_defines.svh]
// Assertion macros used by the checker file of the Cholesky factorizer.
`ifndef CHOLESKY_FACTORIZER_DEFINES_SVH
`define CHOLESKY_FACTORIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CHOL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CHOL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/chol_pkg.sv]
`default_nettype none

package chol_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int SIZE_W  = 4;
    localparam int DATA_W  = 32;
    localparam int ACC_W   = 64;

    typedef logic [DIM_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ASYM  = 2'd1,
        STAT_NOTPD = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SYM_RD,
        ST_SYM_CMP,
        ST_F_INIT,
        ST_F_MAC_RD,
        ST_F_MUL,
        ST_F_ACC,
        ST_F_DIFF_RD,
        ST_F_DIFF,
        ST_F_CHECK,
        ST_F_UNIT,
        ST_F_NEXT,
        ST_O_RD,
        ST_O_EMIT,
        ST_ERR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    a_we;
        addr_t   a_waddr;
        addr_t   a_raddr0;
        addr_t   a_raddr1;
        addr_t   l_raddr0;
        addr_t   l_raddr1;
        logic    l_we;
        addr_t   l_waddr;
        logic    acc_clr;
        logic    mul_en;
        logic    acc_en;
        logic    diff_en;
        logic    root_start;
        logic    div_start;
        logic    emit;
        logic    emit_zero;
        logic    emit_last;
        status_t emit_status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sym_mismatch;
        logic diff_nonpos;
        logic unit_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/chol_datapath.sv]
`default_nettype none

module chol_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire chol_pkg::dp_cmd_t             cmd,
    input  wire logic signed [31:0]            a_element,
    output chol_pkg::dp_stat_t                 stat,
    output logic                               result_strobe,
    output logic signed [31:0]                 l_element,
    output logic [1:0]                         status,
    output logic                               last_of_matrix
);
    import chol_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [DATA_W-1:0] a_mem [DEPTH];
    logic [DATA_W-1:0] l_mem [DEPTH];
    logic [DATA_W-1:0] a_q0_reg, a_q1_reg;
    logic [DATA_W-1:0] l_q0_reg, l_q1_reg;

    logic signed [ACC_W-1:0] prod_reg, acc_reg, acc_next, diff_reg, diff_next;
    logic [DATA_W-1:0]       piv_reg;

    logic [ACC_W-1:0]  work_reg;
    logic [35:0]       rem_reg;
    logic [31:0]       root_reg;
    logic              mode_root_reg;
    logic              neg_reg;
    logic              run_reg;
    logic [6:0]        cnt_reg;

    logic [35:0]       rem_sh, trial;
    logic              root_ge;
    logic [32:0]       div_rem, div_sub;
    logic              div_ge;
    logic [ACC_W:0]    sum_w, sub_w;
    logic [ACC_W-1:0]  a_scaled;
    logic [DATA_W-1:0] unit_result;
    logic [6:0]        last_step;

    logic              valid_reg;
    logic [DATA_W-1:0] l_out_reg;
    status_t           status_reg;
    logic              last_reg;

    // Input matrix store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.a_we)
        begin
            a_mem[cmd.a_waddr] <= a_element;
        end
        a_q0_reg <= a_mem[cmd.a_raddr0];
        a_q1_reg <= a_mem[cmd.a_raddr1];
    end

    // Factor store: written by the root and divide unit.
    always_ff @(posedge clk)
    begin
        if (cmd.l_we)
        begin
            l_mem[cmd.l_waddr] <= unit_result;
        end
        l_q0_reg <= l_mem[cmd.l_raddr0];
        l_q1_reg <= l_mem[cmd.l_raddr1];
    end

    // Saturating accumulate of the dot product and the pivot difference.
    always_comb
    begin
        sum_w    = {acc_reg[ACC_W-1], acc_reg} + {prod_reg[ACC_W-1], prod_reg};
        a_scaled = {{16{a_q0_reg[DATA_W-1]}}, a_q0_reg, 16'h0000};
        sub_w    = {a_scaled[ACC_W-1], a_scaled} - {acc_reg[ACC_W-1], acc_reg};
        if (sum_w[ACC_W] != sum_w[ACC_W-1])
        begin
            acc_next = sum_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = sum_w[ACC_W-1:0];
        end
        if (sub_w[ACC_W] != sub_w[ACC_W-1])
        begin
            diff_next = sub_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            diff_next = sub_w[ACC_W-1:0];
        end
    end

    // Multiply, accumulate and difference registers.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= $signed(l_q0_reg) * $signed(l_q1_reg);
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.diff_en)
        begin
            diff_reg <= diff_next;
            piv_reg  <= l_q1_reg;
        end
    end

    // One step of the root (two bits) and of the divider (one bit).
    always_comb
    begin
        rem_sh  = {rem_reg[33:0], work_reg[ACC_W-1:ACC_W-2]};
        trial   = {2'b00, root_reg, 2'b01};
        root_ge = (rem_sh >= trial);
        div_rem = {rem_reg[31:0], work_reg[ACC_W-1]};
        div_ge  = (div_rem >= {1'b0, piv_reg});
        div_sub = div_rem - {1'b0, piv_reg};
        last_step = mode_root_reg ? 7'd31 : 7'd63;
    end

    // Shared iterative unit control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (cmd.root_start || cmd.div_start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            if (cnt_reg == last_step)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    // Shared iterative unit data.
    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            mode_root_reg <= 1'b1;
            work_reg      <= diff_reg;
            rem_reg       <= '0;
            root_reg      <= '0;
        end
        else if (cmd.div_start)
        begin
            mode_root_reg <= 1'b0;
            neg_reg       <= diff_reg[ACC_W-1];
            work_reg      <= diff_reg[ACC_W-1] ? -diff_reg : diff_reg;
            rem_reg       <= '0;
        end
        else if (run_reg)
        begin
            if (mode_root_reg)
            begin
                work_reg <= {work_reg[ACC_W-3:0], 2'b00};
                rem_reg  <= root_ge ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[30:0], root_ge};
            end
            else
            begin
                work_reg <= {work_reg[ACC_W-2:0], div_ge};
                rem_reg  <= {3'b000, (div_ge ? div_sub : div_rem)};
            end
        end
    end

    // Clamp the unit result to signed 32 bits.
    always_comb
    begin
        if (mode_root_reg)
        begin
            unit_result = root_reg[31] ? 32'h7FFF_FFFF : root_reg;
        end
        else if (neg_reg)
        begin
            unit_result = (work_reg > 64'h0000_0000_8000_0000) ? 32'h8000_0000
                                                                : (~work_reg[31:0] + 32'd1);
        end
        else
        begin
            unit_result = (work_reg > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                : work_reg[31:0];
        end
    end

    // Result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            l_out_reg  <= cmd.emit_zero ? '0 : l_q0_reg;
            status_reg <= cmd.emit_status;
            last_reg   <= cmd.emit_last;
        end
    end

    assign stat.sym_mismatch = (a_q0_reg != a_q1_reg);
    assign stat.diff_nonpos  = diff_reg[ACC_W-1] || (diff_reg == '0);
    assign stat.unit_busy    = run_reg;

    assign result_strobe  = valid_reg;
    assign l_element      = l_out_reg;
    assign status         = status_reg;
    assign last_of_matrix = last_reg;

endmodule

`default_nettype wire

[rtl/chol_ctrl.sv]
`default_nettype none

module chol_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  matrix_size_we,
    input  wire logic [3:0]            matrix_size,
    input  wire chol_pkg::dp_stat_t    stat,
    output logic                       busy,
    output chol_pkg::dp_cmd_t          cmd
);
    import chol_pkg::*;

    state_t            state_reg, state_next;
    idx_t              i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [SIZE_W-1:0] size_reg;
    idx_t              nm1;

    // Largest index of the active dimension; zero acts as one, large values as the maximum.
    always_comb
    begin
        if (size_reg == '0)
        begin
            nm1 = '0;
        end
        else if (size_reg > SIZE_W'(MAX_DIM))
        begin
            nm1 = DIM_W'(MAX_DIM - 1);
        end
        else
        begin
            nm1 = DIM_W'(size_reg - SIZE_W'(1));
        end
    end

    // State, index and size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            size_reg  <= SIZE_W'(MAX_DIM);
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            if (matrix_size_we)
            begin
                size_reg <= matrix_size;
            end
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        busy       = 1'b1;
        cmd        = '0;
        cmd.a_waddr     = {i_reg, j_reg};
        cmd.a_raddr0    = {i_reg, j_reg};
        cmd.a_raddr1    = {j_reg, i_reg};
        cmd.l_raddr0    = {i_reg, k_reg};
        cmd.l_raddr1    = {j_reg, k_reg};
        cmd.l_waddr     = {i_reg, j_reg};
        cmd.emit_status = STAT_OK;

        unique case (state_reg)
            ST_LOAD:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.a_we = 1'b1;
                    if (j_reg == nm1)
                    begin
                        j_next = '0;
                        if (i_reg == nm1)
                        begin
                            i_next     = '0;
                            state_next = ST_SYM_RD;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end

            // Compare each pair below the diagonal with its mirror.
            ST_SYM_RD:
            begin
                if (j_reg == i_reg)
                begin
                    j_next = '0;
                    if (i_reg == nm1)
                    begin
                        i_next     = '0;
                        state_next = ST_F_INIT;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_SYM_CMP;
                end
            end

            ST_SYM_CMP:
            begin
                if (stat.sym_mismatch)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SYM_RD;
                end
            end

            // Dot product over the earlier columns.
            ST_F_INIT:
            begin
                cmd.acc_clr = 1'b1;
                k_next      = '0;
                state_next  = ST_F_MAC_RD;
            end

            ST_F_MAC_RD:
            begin
                state_next = (k_reg == j_reg) ? ST_F_DIFF_RD : ST_F_MUL;
            end

            ST_F_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_F_ACC;
            end

            ST_F_ACC:
            begin
                cmd.acc_en = 1'b1;
                k_next     = k_reg + 1'b1;
                state_next = ST_F_MAC_RD;
            end

            // Read the matrix element and the pivot of column j.
            ST_F_DIFF_RD:
            begin
                cmd.l_raddr1 = {j_reg, j_reg};
                state_next   = ST_F_DIFF;
            end

            ST_F_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = ST_F_CHECK;
            end

            ST_F_CHECK:
            begin
                if (i_reg == j_reg)
                begin
                    if (stat.diff_nonpos)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        cmd.root_start = 1'b1;
                        state_next     = ST_F_UNIT;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_F_UNIT;
                end
            end

            ST_F_UNIT:
            begin
                if (!stat.unit_busy)
                begin
                    cmd.l_we   = 1'b1;
                    state_next = ST_F_NEXT;
                end
            end

            ST_F_NEXT:
            begin
                if (j_reg == i_reg)
                begin
                    j_next = '0;
                    if (i_reg == nm1)
                    begin
                        i_next     = '0;
                        state_next = ST_O_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_F_INIT;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_F_INIT;
                end
            end

            // Stream the factor out row-major.
            ST_O_RD:
            begin
                cmd.l_raddr0 = {i_reg, j_reg};
                state_next   = ST_O_EMIT;
            end

            ST_O_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_zero = (j_reg > i_reg);
                cmd.emit_last = (i_reg == nm1) && (j_reg == nm1);
                if (j_reg == nm1)
                begin
                    j_next = '0;
                    if (i_reg == nm1)
                    begin
                        i_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_O_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_O_RD;
                end
            end

            ST_ERR:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_zero   = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = (i_reg == j_reg) ? STAT_NOTPD : STAT_ASYM;
                i_next          = '0;
                j_next          = '0;
                state_next      = ST_LOAD;
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // A size write restarts loading.
        if (matrix_size_we)
        begin
            i_next = '0;
            j_next = '0;
        end
    end

endmodule

`default_nettype wire

[rtl/cholesky_factorizer.sv]
`default_nettype none

// Cholesky factorizer for signed Q16.16 matrices up to 8 x 8.
//
// Write matrix_size with matrix_size_we while the block is idle; a write also
// restarts loading. Elements of A are then transferred row-major, one per
// cycle, whenever start is high and busy is low. Partial loads produce nothing.
// After the last element busy rises while the block checks symmetry, one pair
// below the diagonal at a time, forms each dot product term by term and runs
// the shared iterative unit for each square root and each division. It then
// emits L row-major on result_strobe, reading each element before its transfer,
// and flags the final one with last_of_matrix. An asymmetric matrix or a
// non-positive pivot gives a single transfer with status set instead. For n = 8
// most of the time from the last element to the final transfer is spent in the
// divider. Reset returns to loading with size 8 and nothing pending.
// Results are presented for exactly one cycle; the receiver cannot stall.

module cholesky_factorizer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] a_element,
    input  wire logic               matrix_size_we,
    input  wire logic [3:0]         matrix_size,
    output logic                    result_strobe,
    output logic signed [31:0]      l_element,
    output logic [1:0]              status,
    output logic                    last_of_matrix
);
    import chol_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    chol_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .matrix_size_we (matrix_size_we),
        .matrix_size    (matrix_size),
        .stat           (stat),
        .busy           (busy),
        .cmd            (cmd)
    );

    chol_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .a_element      (a_element),
        .stat           (stat),
        .result_strobe  (result_strobe),
        .l_element      (l_element),
        .status         (status),
        .last_of_matrix (last_of_matrix)
    );

endmodule

`default_nettype wire

[rtl/chol_checker.sv]
`default_nettype none

`include "cholesky_factorizer_defines.svh"

module chol_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        result_strobe,
    input wire logic [31:0] l_element,
    input wire logic [1:0]  status,
    input wire logic        last_of_matrix
);

    // Only the final transfer of a matrix may appear once the block is idle.
    `CHOL_ASSERT_NOW(a_mid_busy, result_strobe && !last_of_matrix, busy, "result while idle")

    // An error ends the matrix.
    `CHOL_ASSERT_NOW(a_err_last, result_strobe && (status != 2'd0), last_of_matrix,
                     "error not last")

    // An error carries a zero element.
    `CHOL_ASSERT_NOW(a_err_zero, result_strobe && (status != 2'd0), l_element == 32'd0,
                     "error with data")

    // Unused status code never appears.
    `CHOL_ASSERT_NOW(a_stat_code, result_strobe, status != 2'd3, "bad status code")

    // Nothing follows the final transfer in the next cycle.
    `CHOL_ASSERT_NEXT(a_last_gap, result_strobe && last_of_matrix, !result_strobe,
                      "result after last")

endmodule

bind cholesky_factorizer chol_checker u_chol_checker (.*);

`default_nettype wire

[dv/cholesky_factorizer_tb.sv]
`default_nettype none

module cholesky_factorizer_tb;
    import chol_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int ITEM_COUNT = 430;
    localparam int DRAIN_CYCLES = 40;

    // One expected transfer on the result side.
    typedef struct {
        logic signed [31:0] l_val;
        status_t            st;
        logic               last;
    } factor_result_t;

    // Tracks the loaded matrix and predicts the factor transfers.
    class factor_scoreboard;
        logic signed [31:0] a_mem [64];
        logic signed [31:0] l_mem [64];
        logic [3:0]         size_reg;
        int unsigned        load_cnt;
        factor_result_t     pending [$];
        int                 errors;

        function new();
            size_reg = 4'd8;
            load_cnt = 0;
            errors   = 0;
            foreach (a_mem[i])
            begin
                a_mem[i] = '0;
                l_mem[i] = '0;
            end
        endfunction

        function void set_size(logic [3:0] v);
            size_reg = v;
            load_cnt = 0;
        endfunction

        function int unsigned dim();
            if (size_reg == 0)
                return 1;
            if (size_reg > MAX_DIM)
                return MAX_DIM;
            return size_reg;
        endfunction

        function longint add_clamped(longint x, longint y);
            longint r;
            r = x + y;
            if (x[63] == y[63] && r[63] != x[63])
                r = x[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            return r;
        endfunction

        function longint sub_clamped(longint x, longint y);
            longint r;
            r = x - y;
            if (x[63] != y[63] && r[63] != x[63])
                r = x[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            return r;
        endfunction

        // Bitwise integer square root, floor.
        function longint unsigned isqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned one;
            res = 0;
            one = 64'd1 << 62;
            while (one > x)
                one >>= 2;
            while (one != 0)
            begin
                if (x >= res + one)
                begin
                    x -= res + one;
                    res = (res >> 1) + one;
                end
                else
                    res >>= 1;
                one >>= 2;
            end
            return res;
        endfunction

        function void push_error(status_t code);
            factor_result_t e;
            e.l_val = '0;
            e.st    = code;
            e.last  = 1'b1;
            pending.push_back(e);
        endfunction

        // Notes one accepted element; a complete load yields the factor or an error transfer.
        function void note_input(logic signed [31:0] a);
            int unsigned n;
            longint sum;
            longint diff;
            longint q;
            longint unsigned r;
            factor_result_t e;
            n = dim();
            if (load_cnt >= n * n)
                load_cnt = 0;
            a_mem[(load_cnt / n) * 8 + load_cnt % n] = a;
            load_cnt++;
            if (load_cnt < n * n)
                return;
            load_cnt = 0;

            for (int i = 0; i < n; i++)
                for (int j = 0; j < i; j++)
                    if (a_mem[i * 8 + j] != a_mem[j * 8 + i])
                    begin
                        push_error(STAT_ASYM);
                        return;
                    end

            foreach (l_mem[i])
                l_mem[i] = '0;
            for (int i = 0; i < n; i++)
                for (int j = 0; j <= i; j++)
                begin
                    sum = 0;
                    for (int k = 0; k < j; k++)
                        sum = add_clamped(sum, longint'(l_mem[i * 8 + k]) *
                                               longint'(l_mem[j * 8 + k]));
                    diff = sub_clamped(longint'(a_mem[i * 8 + j]) * 65536, sum);
                    if (i == j)
                    begin
                        if (diff <= 0)
                        begin
                            push_error(STAT_NOTPD);
                            return;
                        end
                        r = isqrt(diff);
                        l_mem[i * 8 + j] = (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
                    end
                    else
                    begin
                        q = diff / longint'(l_mem[j * 8 + j]);
                        if (q > 64'sh7FFF_FFFF)
                            q = 64'sh7FFF_FFFF;
                        else if (q < -64'sh8000_0000)
                            q = -64'sh8000_0000;
                        l_mem[i * 8 + j] = q[31:0];
                    end
                end

            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                begin
                    e.l_val = (j <= i) ? l_mem[i * 8 + j] : '0;
                    e.st    = STAT_OK;
                    e.last  = (i * n + j == n * n - 1);
                    pending.push_back(e);
                end
        endfunction

        // Compares one transfer with the oldest expectation.
        function void check(logic signed [31:0] l_val, logic [1:0] st, logic last);
            factor_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer: l_element=%0d status=%0d", l_val, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (l_val !== e.l_val)
            begin
                $error("l_element: expected %0d, actual %0d", e.l_val, l_val);
                errors++;
            end
            if (st !== e.st)
            begin
                $error("status: expected %0d, actual %0d", e.st, st);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last_of_matrix: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] a_element;
    logic               matrix_size_we;
    logic [3:0]         matrix_size;
    logic               result_strobe;
    logic signed [31:0] l_element;
    logic [1:0]         status;
    logic               last_of_matrix;

    factor_scoreboard sb;
    int  sent;
    bit  no_gaps;
    logic signed [31:0] mat [64];

    cholesky_factorizer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .a_element      (a_element),
        .matrix_size_we (matrix_size_we),
        .matrix_size    (matrix_size),
        .result_strobe  (result_strobe),
        .l_element      (l_element),
        .status         (status),
        .last_of_matrix (last_of_matrix)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Result monitor: every strobed transfer is checked.
    always @(posedge clk)
    begin
        if (rst_n && result_strobe === 1'b1)
            sb.check(l_element, status, last_of_matrix);
    end

    // Sends one element; start is left high after the transfer.
    task automatic send_element(logic signed [31:0] v);
        while (!no_gaps && $urandom_range(99) < 32)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        a_element <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(v);
        sent++;
    endtask

    // Waits for every expected transfer, lets the block settle, then writes the size.
    task automatic write_size(logic [3:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
        matrix_size_we <= 1'b1;
        matrix_size    <= v;
        @(posedge clk);
        sb.set_size(v);
        matrix_size_we <= 1'b0;
    endtask

    task automatic send_matrix(int unsigned n);
        for (int i = 0; i < n * n; i++)
            send_element(mat[(i / n) * 8 + i % n]);
    endtask

    // Builds a diagonally dominant symmetric matrix, which is positive definite.
    task automatic make_pd(int unsigned n);
        int range_sel;
        int span;
        longint rowsum;
        range_sel = $urandom_range(2);
        span = (range_sel == 0) ? (1 << 4) : (range_sel == 1) ? (1 << 16) : (1 << 26);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < i; j++)
            begin
                mat[i * 8 + j] = $signed($urandom_range(2 * span)) - span;
                mat[j * 8 + i] = mat[i * 8 + j];
            end
        for (int i = 0; i < n; i++)
        begin
            rowsum = 0;
            for (int j = 0; j < n; j++)
                if (j != i)
                    rowsum += longint'((mat[i * 8 + j] < 0) ? -mat[i * 8 + j]
                                                            : mat[i * 8 + j]);
            mat[i * 8 + i] = 32'(rowsum + longint'($urandom_range(span, 1)));
        end
    endtask

    initial
    begin
        int unsigned n;
        int kind;
        int reps;
        int cut;
        logic [3:0] sz;

        sb             = new();
        sent           = 0;
        no_gaps        = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        a_element      = '0;
        matrix_size_we = 1'b0;
        matrix_size    = 4'd8;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Size one: zero and negative pivots, largest and smallest positives.
        write_size(4'd1);
        send_element(32'sd0);
        send_element(32'sh8000_0000);
        send_element(32'sh7FFF_FFFF);
        send_element(32'sd1);
        send_element(32'sh0001_0000);

        // Size two: asymmetric, then two symmetric matrices with extreme off-diagonals.
        write_size(4'd2);
        mat[0] = 32'sh7FFF_FFFF; mat[1] = 32'sh8000_0000;
        mat[8] = 32'sh7FFF_FFFF; mat[9] = 32'sh7FFF_FFFF;
        send_matrix(2);
        mat[8] = 32'sh8000_0000;
        send_matrix(2);
        mat[0] = 32'sd1; mat[1] = 32'sh7FFF_FFFF; mat[8] = 32'sh7FFF_FFFF; mat[9] = 32'sd1;
        send_matrix(2);
        // A partial load is dropped by the following size write.
        send_element(32'sh0004_0000);

        // Size zero acts as one, sizes above eight act as eight.
        write_size(4'd0);
        send_element(32'sh0009_0000);
        write_size(4'd15);
        make_pd(8);
        // A full load with no idle cycles at all.
        no_gaps = 1'b1;
        send_matrix(8);
        no_gaps = 1'b0;

        // Random phases; most matrices are well formed, the rest are asymmetric by one bit or noise.
        while (sent < ITEM_COUNT)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
                sz = 4'($urandom_range(4, 1));
            else if (kind < 80)
                sz = 4'($urandom_range(7, 5));
            else if (kind < 90)
                sz = 4'd8;
            else
                sz = ($urandom_range(1) != 0) ? 4'd0 : 4'($urandom_range(15, 9));
            write_size(sz);
            n = sb.dim();
            no_gaps = ($urandom_range(5) == 0);
            reps = $urandom_range(3, 1);
            for (int r = 0; r < reps; r++)
            begin
                kind = $urandom_range(99);
                make_pd(n);
                if (kind >= 70 && kind < 80 && n > 1)
                    mat[8] = mat[8] ^ (32'sd1 << $urandom_range(31));
                else if (kind >= 80)
                begin
                    for (int i = 0; i < n; i++)
                        for (int j = 0; j <= i; j++)
                        begin
                            mat[i * 8 + j] = $urandom;
                            mat[j * 8 + i] = mat[i * 8 + j];
                        end
                    if (kind >= 90 && n > 1)
                        mat[1] = $urandom;
                end
                send_matrix(n);
            end
            // Sometimes leave a partial load for the next size write to drop.
            if ($urandom_range(4) == 0)
            begin
                cut = $urandom_range(n * n - 1);
                for (int i = 0; i < cut; i++)
                    send_element($urandom);
            end
        end

        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("cholesky_factorizer_tb: PASS");
        else
            $display("cholesky_factorizer_tb: FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(CLK_PERIOD * 1500000);
        $display("cholesky_factorizer_tb: FAIL");
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/chol_pkg.sv
rtl/chol_datapath.sv
rtl/chol_ctrl.sv
rtl/cholesky_factorizer.sv
rtl/chol_checker.sv
dv/cholesky_factorizer_tb.sv
